>>> src/sst_pkg.sv
// ============================================================================
// sst_pkg: shared types and constants of the source tokenizer
// Character codes, token kinds, byte classes and the lexer-to-queue
// control struct.
// ============================================================================
`default_nettype none

package sst_pkg;

  // Results one input byte can produce at most
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned COUNT_BITS  = 2;
  localparam int unsigned KIND_BITS   = 2;

  // Character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  // Token kind, also the lexer mode while a token is open
  typedef enum logic [KIND_BITS-1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_BLOCK  = 2'd2,
    KIND_STRING = 2'd3
  } sst_kind_e;

  // Load command from the lexer into the result queue
  typedef struct packed {
    logic                  load;
    logic [COUNT_BITS-1:0] count;
  } sst_load_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
           (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

>>> src/schema_source_tokenizer.sv
// ============================================================================
// schema_source_tokenizer: streaming C-style source tokenizer
// Byte-in, token-out lexer for words, punctuation, comments and strings.
// ============================================================================
// Takes one byte per cycle and returns tokens as start/end byte offsets, the
// start line and column, and a kind. Each byte is decided once the next byte
// arrives, so a token comes out one byte after its closing character, and
// the final byte of a stream (end_of_stream_i) flushes whatever is open. A
// byte gives zero to three tokens; these land together in a three-entry
// result queue and leave one per cycle while the receiver is ready, run_last_o
// marking the last of the group. Input is taken every cycle while each byte
// yields at most one token and the receiver keeps up; a byte that yields more
// tokens holds input while the queue drains, and input also waits while the
// receiver stalls. Offsets, lines and columns saturate at all ones.
`default_nettype none

module schema_source_tokenizer #(
  parameter int unsigned OFFSET_BITS   = 24,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        byte_value_i,
  input  wire logic                              end_of_stream_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [OFFSET_BITS-1:0]                 token_start_o,
  output logic [OFFSET_BITS-1:0]                 token_end_o,
  output logic [POSITION_BITS-1:0]               start_line_o,
  output logic [POSITION_BITS-1:0]               start_column_o,
  output logic [sst_pkg::KIND_BITS-1:0]          token_kind_o,
  output logic                                   run_last_o
);

  localparam int unsigned RES_BITS = 2 * OFFSET_BITS + 2 * POSITION_BITS +
                                     sst_pkg::KIND_BITS;

  logic                                          accept;
  sst_pkg::sst_load_t                            load;
  logic [sst_pkg::MAX_RESULTS-1:0][RES_BITS-1:0] res;
  logic [RES_BITS-1:0]                           q_data;

  assign accept = in_valid_i && in_ready_o;

  sst_lex #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_lex (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_value_i),
    .eos_i    (end_of_stream_i),
    .load_o   (load),
    .res_o    (res)
  );

  sst_outq #(
    .WIDTH (RES_BITS)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .data_i      (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .last_o      (run_last_o),
    .data_o      (q_data),
    .can_load_o  (in_ready_o)
  );

  // Unpack the head result
  assign {token_start_o, token_end_o, start_line_o, start_column_o, token_kind_o} = q_data;

endmodule

`default_nettype wire

>>> src/sst_lex.sv
// ============================================================================
// sst_lex: lexer state and single-pass token decision
// Holds one byte back, decides it against the incoming byte and forms up to
// three results per accepted byte, packed first to last.
// ============================================================================
`default_nettype none

module sst_lex #(
  parameter int unsigned OFFSET_BITS   = 24,
  parameter int unsigned POSITION_BITS = 16,
  localparam int unsigned RES_BITS     = 2 * OFFSET_BITS + 2 * POSITION_BITS
                                         + sst_pkg::KIND_BITS
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       accept_i,
  input  wire logic [7:0]                                 byte_i,
  input  wire logic                                       eos_i,
  output sst_pkg::sst_load_t                              load_o,
  output logic [sst_pkg::MAX_RESULTS-1:0][RES_BITS-1:0]   res_o
);

  // State registers
  logic                     tok_q, tok_d;
  logic [OFFSET_BITS-1:0]   start_q, start_d;
  logic [POSITION_BITS-1:0] oline_q, oline_d;
  logic [POSITION_BITS-1:0] ocol_q, ocol_d;
  sst_pkg::sst_kind_e       mode_q, mode_d;
  logic [7:0]               held_q, held_d;
  logic                     hvalid_q, hvalid_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;

  // Held-byte decision
  logic                     ch_space, ch_word, ch_crlf, nx_slash, nx_star;
  logic                     close_old, fresh, opener, quote, fresh_close;
  logic                     skip_cnt, crlf_skip, skip;
  logic [OFFSET_BITS-1:0]   old_end;
  logic [OFFSET_BITS-1:0]   off_inc;
  logic [POSITION_BITS-1:0] col_inc, line_inc;

  // State after the held byte
  logic                     tok1;
  logic [OFFSET_BITS-1:0]   start1, off1, off1_inc;
  logic [POSITION_BITS-1:0] oline1, ocol1, line1, col1, col1_inc;
  sst_pkg::sst_kind_e       mode1;

  // Candidate results
  logic                     c0_v, c1_v, c2_v;
  logic [RES_BITS-1:0]      c0, c1, c2;

  // Classify the held byte and the lookahead
  assign ch_space = sst_pkg::is_space(held_q);
  assign ch_word  = sst_pkg::is_word(held_q);
  assign ch_crlf  = (held_q == sst_pkg::CH_CR) || (held_q == sst_pkg::CH_LF);
  assign nx_slash = (byte_i == sst_pkg::CH_SLASH);
  assign nx_star  = (byte_i == sst_pkg::CH_STAR);

  assign off_inc  = (off_q == '1)  ? off_q  : off_q + 1'b1;
  assign col_inc  = (col_q == '1)  ? col_q  : col_q + 1'b1;
  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;

  // Decide the held byte with the incoming byte visible
  always_comb begin
    close_old = hvalid_q && tok_q && !ch_word &&
                ((mode_q == sst_pkg::KIND_PLAIN) ||
                 ((mode_q == sst_pkg::KIND_LINE) && ch_crlf) ||
                 ((mode_q == sst_pkg::KIND_BLOCK) && (held_q == sst_pkg::CH_STAR) &&
                  nx_slash) ||
                 ((mode_q == sst_pkg::KIND_STRING) && (held_q == sst_pkg::CH_QUOTE)));

    unique case (mode_q)
      sst_pkg::KIND_PLAIN,
      sst_pkg::KIND_LINE:  old_end = off_q - 1'b1;
      sst_pkg::KIND_BLOCK: old_end = off_inc;
      default:             old_end = off_q;
    endcase

    fresh       = hvalid_q && !ch_space &&
                  (!tok_q || ((mode_q == sst_pkg::KIND_PLAIN) && !ch_word));
    opener      = fresh && !ch_word && (held_q == sst_pkg::CH_SLASH) &&
                  (nx_slash || nx_star);
    quote       = fresh && !ch_word && (held_q == sst_pkg::CH_QUOTE);
    fresh_close = fresh && !ch_word && !opener && !quote;

    skip_cnt    = opener ||
                  (hvalid_q && tok_q && (mode_q == sst_pkg::KIND_BLOCK) &&
                   (held_q == sst_pkg::CH_STAR) && nx_slash) ||
                  (hvalid_q && tok_q && (mode_q == sst_pkg::KIND_STRING) &&
                   (held_q == sst_pkg::CH_BSLASH));
    crlf_skip   = hvalid_q && (held_q == sst_pkg::CH_CR) &&
                  (byte_i == sst_pkg::CH_LF) && !skip_cnt;
    skip        = skip_cnt || crlf_skip;

    // Open-token state after the held byte
    tok1   = tok_q;
    start1 = start_q;
    oline1 = oline_q;
    ocol1  = ocol_q;
    mode1  = mode_q;
    if (fresh) begin
      tok1   = ch_word || opener || quote;
      start1 = off_q;
      oline1 = line_q;
      ocol1  = col_q;
      if (opener) begin
        mode1 = nx_slash ? sst_pkg::KIND_LINE : sst_pkg::KIND_BLOCK;
      end else if (quote) begin
        mode1 = sst_pkg::KIND_STRING;
      end else begin
        mode1 = sst_pkg::KIND_PLAIN;
      end
    end else if (close_old) begin
      tok1  = 1'b0;
      mode1 = sst_pkg::KIND_PLAIN;
    end

    // Position after the held byte
    off1  = off_q;
    line1 = line_q;
    col1  = col_q;
    if (hvalid_q) begin
      off1 = off_inc;
      if (ch_crlf) begin
        line1 = line_inc;
        col1  = POSITION_BITS'(1);
      end else begin
        col1 = col_inc;
      end
    end
  end

  assign off1_inc = (off1 == '1) ? off1 : off1 + 1'b1;
  assign col1_inc = (col1 == '1) ? col1 : col1 + 1'b1;

  // Form candidate results in emission order
  always_comb begin
    c0_v = close_old;
    c0   = {start_q, old_end, oline_q, ocol_q, mode_q};
    c1_v = fresh_close;
    c1   = {off_q, off_q, line_q, col_q, sst_pkg::KIND_PLAIN};
    c2_v = eos_i && (tok1 || (!skip && !sst_pkg::is_space(byte_i)));
    if (tok1) begin
      c2 = {start1, off1, oline1, ocol1, mode1};
    end else begin
      c2 = {off1, off1, line1, col1, sst_pkg::KIND_PLAIN};
    end
  end

  // Pack valid candidates to the front
  always_comb begin
    res_o[0] = c0_v ? c0 : (c1_v ? c1 : c2);
    res_o[1] = (c0_v && c1_v) ? c1 : c2;
    res_o[2] = c2;
    load_o.load  = accept_i;
    load_o.count = sst_pkg::COUNT_BITS'(c0_v) + sst_pkg::COUNT_BITS'(c1_v) +
                   sst_pkg::COUNT_BITS'(c2_v);
  end

  // Next state: clear at end of stream, drop a consumed lookahead, else hold it
  always_comb begin
    tok_d    = tok1;
    start_d  = start1;
    oline_d  = oline1;
    ocol_d   = ocol1;
    mode_d   = mode1;
    held_d   = byte_i;
    hvalid_d = 1'b1;
    off_d    = off1;
    line_d   = line1;
    col_d    = col1;
    if (eos_i) begin
      tok_d    = 1'b0;
      start_d  = '0;
      oline_d  = POSITION_BITS'(1);
      ocol_d   = POSITION_BITS'(1);
      mode_d   = sst_pkg::KIND_PLAIN;
      held_d   = '0;
      hvalid_d = 1'b0;
      off_d    = '0;
      line_d   = POSITION_BITS'(1);
      col_d    = POSITION_BITS'(1);
    end else if (skip) begin
      held_d   = held_q;
      hvalid_d = 1'b0;
      off_d    = off1_inc;
      col_d    = skip_cnt ? col1_inc : col1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      start_q  <= '0;
      oline_q  <= POSITION_BITS'(1);
      ocol_q   <= POSITION_BITS'(1);
      mode_q   <= sst_pkg::KIND_PLAIN;
      held_q   <= '0;
      hvalid_q <= 1'b0;
      off_q    <= '0;
      line_q   <= POSITION_BITS'(1);
      col_q    <= POSITION_BITS'(1);
    end else if (accept_i) begin
      tok_q    <= tok_d;
      start_q  <= start_d;
      oline_q  <= oline_d;
      ocol_q   <= ocol_d;
      mode_q   <= mode_d;
      held_q   <= held_d;
      hvalid_q <= hvalid_d;
      off_q    <= off_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

endmodule

`default_nettype wire

>>> src/sst_outq.sv
// ============================================================================
// sst_outq: result register and drain queue
// Takes up to three results of one byte at once and hands them out one per
// transfer, marking the last of each group.
// ============================================================================
`default_nettype none

module sst_outq #(
  parameter int unsigned WIDTH = 98
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire sst_pkg::sst_load_t                       load_i,
  input  wire logic [sst_pkg::MAX_RESULTS-1:0][WIDTH-1:0] data_i,
  input  wire logic                                     out_ready_i,
  output logic                                          out_valid_o,
  output logic                                          last_o,
  output logic [WIDTH-1:0]                              data_o,
  output logic                                          can_load_o
);

  logic [sst_pkg::COUNT_BITS-1:0]                count_q;
  logic [sst_pkg::MAX_RESULTS-1:0][WIDTH-1:0]    slot_q;
  logic                                          pop;

  assign out_valid_o = (count_q != '0);
  assign last_o      = (count_q == sst_pkg::COUNT_BITS'(1));
  assign data_o      = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // Accept a new group when the queue is empty or empties in this cycle
  assign can_load_o  = (count_q == '0) || (last_o && out_ready_i);

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i.load) begin
      count_q <= load_i.count;
    end else if (pop) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Load a group or advance the queue
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      slot_q <= data_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

`default_nettype wire

>>> src/sst_checker.sv
// ============================================================================
// sst_checker: port-level checks of the source tokenizer
// Watches the top-level ports for result holding, input stalls, grouping and nonzero positions.
// ============================================================================
`default_nettype none

module sst_checker #(
  parameter int unsigned OFFSET_BITS   = 24,
  parameter int unsigned POSITION_BITS = 16
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [OFFSET_BITS-1:0]       token_start_o,
  input wire logic [OFFSET_BITS-1:0]       token_end_o,
  input wire logic [POSITION_BITS-1:0]     start_line_o,
  input wire logic [POSITION_BITS-1:0]     start_column_o,
  input wire logic [sst_pkg::KIND_BITS-1:0] token_kind_o,
  input wire logic                         run_last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_start_o) &&
      $stable(token_end_o) && $stable(start_line_o) && $stable(start_column_o) &&
      $stable(token_kind_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // Never stall input while the result side is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

  // Keep the rest of a group right behind a transfer that is not its last
  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("result group broken");

  // Lines and columns count from one
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (start_line_o != '0) && (start_column_o != '0))
    else $error("zero line or column");

endmodule

bind schema_source_tokenizer sst_checker #(
  .OFFSET_BITS   (OFFSET_BITS),
  .POSITION_BITS (POSITION_BITS)
) u_sst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_start_o  (token_start_o),
  .token_end_o    (token_end_o),
  .start_line_o   (start_line_o),
  .start_column_o (start_column_o),
  .token_kind_o   (token_kind_o),
  .run_last_o     (run_last_o)
);

`default_nettype wire
